>>> hdl/periodic_tick_slot_scheduler_macros.svh
// Assertion helpers shared by the scheduler modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PERIODIC_TICK_SLOT_SCHEDULER_MACROS_SVH
`define PERIODIC_TICK_SLOT_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pts_pkg.sv
`default_nettype none

package pts_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int MASK_W    = 64;
  localparam int TICK_W    = 32;
  localparam int MULT_W    = 16;
  localparam int SCALE_W   = 16;
  localparam int SLOT_W    = 6;
  localparam int OP_W      = 2;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd1;

  // Register index, taken from paddr[2].
  localparam logic REG_PERIOD_SCALE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 2'd0,
    OP_INSTALL   = 2'd1,
    OP_UNINSTALL = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_CHK,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic mul_en;
    logic div_start;
    logic fire_chk;
    logic slot_done;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic item_tick;
    logic scan_more;
    logic prod_zero;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/pts_rem.sv
`default_nettype none

module pts_rem
  import pts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TICK_W-1:0] dividend,
  input  wire logic [TICK_W-1:0] divisor,
  output logic                   done,
  output logic                   rem_zero
);

  localparam int STEP_W = $clog2(TICK_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [TICK_W-1:0] rem_r;
  logic [TICK_W-1:0] dvd_r;
  logic [TICK_W-1:0] dsr_r;

  logic [TICK_W:0]   trial;
  logic [TICK_W-1:0] rem_nxt;

  // Restoring division, one quotient bit per cycle; only the remainder is kept.
  always_comb begin
    trial = {rem_r, dvd_r[TICK_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = TICK_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(TICK_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[TICK_W-2:0], 1'b0};
    end
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

`default_nettype wire

>>> hdl/pts_ctrl.sv
`default_nettype none

module pts_ctrl
  import pts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.item_tick ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: state_nxt = sts.scan_more ? S_MUL : S_FIN;
      S_MUL:  state_nxt = S_CHK;
      S_CHK:  state_nxt = sts.prod_zero ? S_SCAN : S_DIV;
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_SCAN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_SCAN: cmd.rd_en = sts.scan_more;
      S_MUL:  cmd.mul_en = 1'b1;
      S_CHK: begin
        cmd.div_start = !sts.prod_zero;
        cmd.slot_done = sts.prod_zero;
      end
      S_DIV: begin
        cmd.fire_chk  = sts.div_done;
        cmd.slot_done = sts.div_done;
      end
      S_FIN:  cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`include "periodic_tick_slot_scheduler_macros.svh"

  `PTS_ASSERT_NOW(a_load_when_free, cmd.load_out, out_free, "result loaded over a pending beat")
  `PTS_ASSERT_NEXT(a_plain_item_fin, cmd.accept && !sts.item_tick, state_r == S_FIN,
                   "non-tick item did not go straight to finish")
  `PTS_ASSERT_NOW(a_valid_from_load, $rose(out_valid_r), $past(cmd.load_out),
                  "output valid rose without a load")

endmodule

`default_nettype wire

>>> hdl/pts_dp.sv
`default_nettype none

module pts_dp
  import pts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [OP_W-1:0]    in_opcode,
  input  wire logic [SLOT_W-1:0]  in_slot_index,
  input  wire logic [MULT_W-1:0]  in_period_multiplier,
  output logic [MASK_W-1:0]       out_fire_mask,
  output logic [TICK_W-1:0]       out_tick_count,
  output logic [SLOT_W-1:0]       out_assigned_slot,
  output logic                    out_status,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [MULT_W-1:0]  slot_mem [SLOTS];
  logic [MULT_W-1:0]  rd_data_r;

  logic [SCALE_W-1:0] scale_r;
  logic [TICK_W-1:0]  cnt_r;
  logic [CNT_W-1:0]   slots_used_r;
  logic [CNT_W-1:0]   scan_r;
  logic [TICK_W-1:0]  prod_r;
  logic [MASK_W-1:0]  mask_r;
  logic [SLOT_W-1:0]  res_assigned_r;
  logic               res_status_r;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [MULT_W-1:0]  wr_data;
  logic               tbl_full;
  logic               idx_ok;
  logic [SLOT_W-1:0]  fire_idx;
  logic               div_done;
  logic               rem_zero;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PERIOD_SCALE) ? APB_DW'(scale_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_PERIOD_SCALE)) begin
      scale_r <= pwdata[SCALE_W-1:0];
    end
  end

  // Slot table write port: installs append, uninstalls clear an entry.
  assign tbl_full = (slots_used_r >= CNT_W'(SLOTS));
  assign idx_ok   = ({1'b0, in_slot_index} < (SLOT_W + 1)'(SLOTS));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slots_used_r[IDX_W-1:0];
    wr_data = in_period_multiplier;
    if (cmd.accept) begin
      case (in_opcode)
        OP_INSTALL: wr_en = !tbl_full;
        OP_UNINSTALL: begin
          wr_en   = idx_ok;
          wr_addr = in_slot_index[IDX_W-1:0];
          wr_data = '0;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= slot_mem[scan_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= {{(TICK_W - SCALE_W){1'b0}}, scale_r} *
                {{(TICK_W - MULT_W){1'b0}}, rd_data_r};
    end
  end

  // Item bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      slots_used_r <= '0;
    end else if (cmd.accept) begin
      if (in_opcode == OP_TICK) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if ((in_opcode == OP_INSTALL) && !tbl_full) begin
        slots_used_r <= slots_used_r + 1'b1;
      end
    end
  end

  assign fire_idx = SLOT_W'(scan_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mask_r         <= '0;
      scan_r         <= '0;
      res_assigned_r <= '0;
      res_status_r   <= 1'b0;
      if (in_opcode == OP_INSTALL) begin
        res_status_r <= tbl_full;
        if (!tbl_full) begin
          res_assigned_r <= SLOT_W'(slots_used_r);
        end
      end
    end else begin
      if (cmd.fire_chk && rem_zero) begin
        mask_r[fire_idx] <= 1'b1;
      end
      if (cmd.slot_done) begin
        scan_r <= scan_r + 1'b1;
      end
    end
  end

  pts_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cnt_r),
    .divisor  (prod_r),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_fire_mask     <= mask_r;
      out_tick_count    <= cnt_r;
      out_assigned_slot <= res_assigned_r;
      out_status        <= res_status_r;
    end
  end

  always_comb begin
    sts.item_tick = (in_opcode == OP_TICK);
    sts.scan_more = (scan_r < slots_used_r);
    sts.prod_zero = (prod_r == '0);
    sts.div_done  = div_done;
  end

`include "periodic_tick_slot_scheduler_macros.svh"

  `PTS_ASSERT_NOW(a_used_bound, 1'b1, slots_used_r <= CNT_W'(SLOTS),
                  "slot count ran past the table size")
  `PTS_ASSERT_NOW(a_read_in_use, cmd.rd_en, scan_r < slots_used_r,
                  "scan read a slot that was never installed")
  `PTS_ASSERT_NOW(a_div_nonzero, cmd.div_start, prod_r != '0,
                  "remainder started with a zero period")

endmodule

`default_nettype wire

>>> hdl/periodic_tick_slot_scheduler.sv
// Channel  Handshake                 Payload
// in       in_valid / in_ready       in_opcode, in_slot_index, in_period_multiplier
// out      out_valid / out_ready     out_fire_mask, out_tick_count, out_assigned_slot,
//                                    out_status
// cfg      psel, penable, pwrite     paddr, pwdata, prdata, pready (always high)
//
// Install, uninstall and unused opcodes go from accept straight to the finish state.
// For a tick, each installed slot reads the table and multiplies, then, unless its
// period is zero, runs a bit-serial remainder unit against the tick count.
// Reset is synchronous; the slot table needs no clearing pass.
// A new beat is accepted while the previous result still waits on out_ready.
`default_nettype none

module periodic_tick_slot_scheduler
  import pts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_opcode,
  input  wire logic [SLOT_W-1:0] in_slot_index,
  input  wire logic [MULT_W-1:0] in_period_multiplier,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [MASK_W-1:0]      out_fire_mask,
  output logic [TICK_W-1:0]      out_tick_count,
  output logic [SLOT_W-1:0]      out_assigned_slot,
  output logic                   out_status,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  cmd_t cmd;
  sts_t sts;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pts_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_opcode),
    .in_slot_index        (in_slot_index),
    .in_period_multiplier (in_period_multiplier),
    .out_fire_mask        (out_fire_mask),
    .out_tick_count       (out_tick_count),
    .out_assigned_slot    (out_assigned_slot),
    .out_status           (out_status),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

endmodule

`default_nettype wire

>>> sim/periodic_tick_slot_scheduler_checker.sv
`timescale 1ns / 100ps

module periodic_tick_slot_scheduler_checker
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic [MULT_W-1:0] in_period_multiplier,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [MASK_W-1:0] out_fire_mask,
  input  logic [TICK_W-1:0] out_tick_count,
  input  logic [SLOT_W-1:0] out_assigned_slot,
  input  logic              out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    logic [TICK_W-1:0] tick_count;
    logic [SLOT_W-1:0] assigned_slot;
    logic              status;
  } slot_result_t;

  // Shadow copy of the scheduler state.
  logic [TICK_W-1:0]  ticks;
  logic [MULT_W-1:0]  multipliers [SLOTS_DEF];
  logic [6:0]         installed;
  logic [SCALE_W-1:0] scale;

  slot_result_t expected_results [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic void schedule_beat(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx,
                                        logic [MULT_W-1:0] mult);
    slot_result_t res;
    logic [31:0] period;
    res = '0;
    case (op)
      OP_TICK: begin
        ticks = ticks + 1'b1;
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (i < installed) begin
            period = 32'(scale) * 32'(multipliers[i]);
            // A zero period means the slot is disabled.
            if (period != 0 && (ticks % period) == 0) res.fire_mask[i] = 1'b1;
          end
        end
      end
      OP_INSTALL: begin
        if (installed >= SLOTS_DEF) begin
          res.status = 1'b1;
        end else begin
          multipliers[installed] = mult;
          res.assigned_slot = installed[SLOT_W-1:0];
          installed = installed + 1'b1;
        end
      end
      OP_UNINSTALL: begin
        multipliers[idx] = '0;
      end
      default: begin
      end
    endcase
    res.tick_count = ticks;
    expected_results.push_back(res);
  endfunction

  always @(posedge clk) begin : watch
    slot_result_t want;
    if (!rst_n) begin
      ticks = '0;
      installed = '0;
      scale = SCALE_RST;
      for (int i = 0; i < SLOTS_DEF; i++) multipliers[i] = '0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_PERIOD_SCALE) begin
        scale = pwdata[SCALE_W-1:0];
      end
      if (in_valid && in_ready) begin
        schedule_beat(in_opcode, in_slot_index, in_period_multiplier);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual mask %h count %h",
                   $time, out_fire_mask, out_tick_count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_fire_mask !== want.fire_mask) begin
            $display("%0t: fire_mask expected %h actual %h", $time, want.fire_mask,
                     out_fire_mask);
            mismatches++;
          end
          if (out_tick_count !== want.tick_count) begin
            $display("%0t: tick_count expected %h actual %h", $time, want.tick_count,
                     out_tick_count);
            mismatches++;
          end
          if (out_assigned_slot !== want.assigned_slot) begin
            $display("%0t: assigned_slot expected %0d actual %0d", $time,
                     want.assigned_slot, out_assigned_slot);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %b actual %b", $time, want.status, out_status);
            mismatches++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> sim/periodic_tick_slot_scheduler_tb.sv
`timescale 1ns / 100ps

module periodic_tick_slot_scheduler_tb;
  import pts_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_opcode;
  logic [SLOT_W-1:0] in_slot_index;
  logic [MULT_W-1:0] in_period_multiplier;
  logic              out_valid;
  logic              out_ready;
  logic [MASK_W-1:0] out_fire_mask;
  logic [TICK_W-1:0] out_tick_count;
  logic [SLOT_W-1:0] out_assigned_slot;
  logic              out_status;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;
  int installs_sent;
  bit tx_gaps;
  bit rx_steady;
  bit hold_req;

  periodic_tick_slot_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_slot_index       (in_slot_index),
    .in_period_multiplier(in_period_multiplier),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_fire_mask       (out_fire_mask),
    .out_tick_count      (out_tick_count),
    .out_assigned_slot   (out_assigned_slot),
    .out_status          (out_status),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  periodic_tick_slot_scheduler_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_slot_index       (in_slot_index),
    .in_period_multiplier(in_period_multiplier),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_fire_mask       (out_fire_mask),
    .out_tick_count      (out_tick_count),
    .out_assigned_slot   (out_assigned_slot),
    .out_status          (out_status),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .mismatches          (mismatches),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random back-pressure, a steady stretch, and one long hold-off.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 27);
      end
    end
  end

  task automatic put_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx,
                          logic [MULT_W-1:0] mult);
    logic accepted;
    while (tx_gaps && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_slot_index <= idx;
    in_period_multiplier <= mult;
    if (op == OP_INSTALL) installs_sent++;
    do begin
      @(negedge clk);
      accepted = in_ready;
      @(posedge clk);
    end while (!accepted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    // Upper data bits are junk; only the low half is kept.
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic put_random_item();
    int pick;
    logic [OP_W-1:0] op;
    logic [SLOT_W-1:0] idx;
    logic [MULT_W-1:0] mult;
    pick = $urandom_range(99);
    if (pick < 44) op = OP_TICK;
    else if (pick < 72) op = OP_INSTALL;
    else if (pick < 90) op = OP_UNINSTALL;
    else op = OP_UNUSED;
    idx = $urandom_range(1) ? SLOT_W'($urandom_range(15)) : SLOT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) mult = MULT_W'($urandom_range(1, 6));
    else if (pick < 80) mult = '0;
    else mult = MULT_W'($urandom);
    put_item(op, idx, mult);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= '0;
    in_slot_index <= '0;
    in_period_multiplier <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    installs_sent = 0;
    tx_gaps = 1'b1;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_scale(16'd1);
    // Empty table, unused opcode, zero and maximum multipliers.
    put_item(OP_TICK, '0, '0);
    put_item(OP_UNUSED, 6'd63, 16'hffff);
    put_item(OP_INSTALL, 6'd63, 16'd1);
    put_item(OP_INSTALL, '0, 16'd2);
    put_item(OP_INSTALL, '0, 16'd0);
    put_item(OP_INSTALL, 6'd42, 16'hffff);
    repeat (4) put_item(OP_TICK, '0, '0);
    put_item(OP_UNINSTALL, 6'd1, '0);
    repeat (2) put_item(OP_TICK, 6'd63, 16'hffff);
    // Uninstall of a slot that was never installed.
    put_item(OP_UNINSTALL, 6'd63, '0);
    put_item(OP_UNINSTALL, 6'd0, 16'hffff);
    put_item(OP_TICK, '0, '0);
    put_item(OP_INSTALL, '0, 16'd3);
    repeat (3) put_item(OP_TICK, '0, '0);
    wait_drained();

    // A zero scale disables every slot.
    write_scale(16'd0);
    repeat (5) put_item(OP_TICK, '0, '0);
    wait_drained();

    write_scale(16'hffff);
    put_item(OP_INSTALL, '0, 16'd1);
    repeat (3) put_item(OP_TICK, '0, '0);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_scale(16'd2);
        1: write_scale(16'd1);
        2: write_scale(SCALE_W'($urandom));
        default: write_scale(SCALE_W'($urandom_range(1, 4)));
      endcase
      tx_gaps = (phase != 3);
      rx_steady = (phase == 3);
      for (int n = 0; n < 50; n++) begin
        if (phase == 1 && n == 10) hold_req = 1'b1;
        if (phase == 2 && n == 25) wait_drained();
        put_random_item();
      end
      wait_drained();
    end
    tx_gaps = 1'b1;
    rx_steady = 1'b0;

    // Make sure the table fills and further installs are refused.
    while (installs_sent < SLOTS_DEF + 2) put_item(OP_INSTALL, SLOT_W'($urandom), 16'd1);
    repeat (2) put_item(OP_TICK, '0, '0);
    wait_drained();
    repeat (100) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
